// File: src/grwd_pkg.sv
// ----------------------------------------------------------------------------
// grwd_pkg
// Shared widths, codes and word formats of the grid ray wall distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package grwd_pkg;

	localparam int POS_W      = 24;
	localparam int DIR_W      = 16;
	localparam int DIST_W     = 24;
	localparam int DIM_W      = 7;
	localparam int EDIM_W     = 9;
	localparam int TILE_W     = 6;
	localparam int CELL_W     = 18;
	localparam int FC_W       = 25;
	localparam int LINE_W     = 34;
	localparam int PROD_W     = 48;
	localparam int MAG_W      = 17;
	localparam int QPROD_W    = 40;
	localparam int SQ_W       = 50;
	localparam int CNT_W      = 6;
	localparam int DIV_STEPS  = 40;
	localparam int ROOT_STEPS = 25;
	localparam int CFG_IDX_W  = 1;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_QUERY = 2'd1,
		OP_ZERO  = 2'd2
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic                     wr_en;
		logic [TILE_W-1:0]        tile_col;
		logic [TILE_W-1:0]        tile_row;
		logic                     tile_solid;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [DIR_W-1:0]  dir_x;
		logic signed [DIR_W-1:0]  dir_y;
		logic signed [CELL_W-1:0] cell_x;
		logic signed [CELL_W-1:0] cell_y;
		logic [FC_W-1:0]          fc_x;
		logic [FC_W-1:0]          fc_y;
	} cmd_t;

	typedef struct packed {
		logic signed [LINE_W-1:0] d;
		logic signed [DIR_W-1:0]  fa;
		logic signed [DIR_W-1:0]  fo;
	} dist_req_t;

	typedef struct packed {
		logic              hit_solid;
		logic [DIST_W-1:0] distance;
	} res_t;

endpackage

`default_nettype wire

// File: src/grwd_ram.sv
// ----------------------------------------------------------------------------
// grwd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module grwd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/grwd_fifo.sv
// ----------------------------------------------------------------------------
// grwd_fifo
// Short word queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module grwd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/grwd_dist.sv
// ----------------------------------------------------------------------------
// grwd_dist
// Distance unit: cross-axis offset by multiply and restoring divide, then
// bit-pair integer square root of the sum of squares, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module grwd_dist (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire grwd_pkg::dist_req_t        req,
	output logic                            done,
	output logic [grwd_pkg::DIST_W-1:0]     dist_len
);

	typedef enum logic [7:0] {
		D_IDLE = 8'b0000_0001,
		D_MUL  = 8'b0000_0010,
		D_DIV  = 8'b0000_0100,
		D_SQA  = 8'b0000_1000,
		D_SQB  = 8'b0001_0000,
		D_ADD  = 8'b0010_0000,
		D_ROOT = 8'b0100_0000,
		D_DONE = 8'b1000_0000
	} dstate_t;

	dstate_t                          state_q;
	logic [grwd_pkg::CNT_W-1:0]       cnt_q;
	logic [grwd_pkg::DIST_W-1:0]      ua_q;
	logic [grwd_pkg::MAG_W-1:0]       afa_q;
	logic [grwd_pkg::MAG_W-1:0]       afo_q;
	logic [grwd_pkg::QPROD_W-1:0]     prod_q;
	logic [grwd_pkg::MAG_W-1:0]       rem_q;
	logic [grwd_pkg::SQ_W-1:0]        sq_q;
	logic [grwd_pkg::SQ_W-1:0]        sq2_q;
	logic [grwd_pkg::SQ_W-1:0]        v_q;
	logic [grwd_pkg::SQ_W-1:0]        r_q;
	logic [grwd_pkg::SQ_W-1:0]        b_q;
	logic [grwd_pkg::DIST_W-1:0]      dist_q;

	logic [grwd_pkg::LINE_W-1:0]      ua_full;
	logic [grwd_pkg::MAG_W-1:0]       afa_in;
	logic [grwd_pkg::MAG_W-1:0]       afo_in;
	logic [grwd_pkg::MAG_W:0]         trial;
	logic                             trial_ge;
	logic [grwd_pkg::SQ_W-1:0]        rb;
	logic                             root_ge;
	logic [grwd_pkg::SQ_W-1:0]        r_n;
	logic [grwd_pkg::SQ_W-1:0]        v_n;

	assign ua_full = req.d[grwd_pkg::LINE_W-1] ? (grwd_pkg::LINE_W'(0) - req.d) : req.d;
	assign afa_in  = req.fa[grwd_pkg::DIR_W-1] ?
		(grwd_pkg::MAG_W'(0) - {req.fa[grwd_pkg::DIR_W-1], req.fa}) : {1'b0, req.fa};
	assign afo_in  = req.fo[grwd_pkg::DIR_W-1] ?
		(grwd_pkg::MAG_W'(0) - {req.fo[grwd_pkg::DIR_W-1], req.fo}) : {1'b0, req.fo};

	assign trial    = {rem_q, prod_q[grwd_pkg::QPROD_W-1]};
	assign trial_ge = (trial >= {1'b0, afa_q});

	assign rb      = r_q + b_q;
	assign root_ge = (v_q >= rb);
	assign r_n     = root_ge ? ((r_q >> 1) + b_q) : (r_q >> 1);
	assign v_n     = root_ge ? (v_q - rb) : v_q;

	assign done     = (state_q == D_DONE);
	assign dist_len = dist_q;

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				ua_q  <= ua_full[grwd_pkg::DIST_W-1:0];
				afa_q <= afa_in;
				afo_q <= afo_in;
				if (ua_full == '0) begin
					dist_q <= '0;
				end else begin
					dist_q <= grwd_pkg::DIST_MAX;
				end
			end
			D_MUL: begin
				prod_q <= grwd_pkg::QPROD_W'(ua_q * afo_q);
				rem_q  <= '0;
			end
			D_DIV: begin
				prod_q <= {prod_q[grwd_pkg::QPROD_W-2:0], trial_ge};
				rem_q  <= trial_ge ? grwd_pkg::MAG_W'(trial - {1'b0, afa_q})
					: trial[grwd_pkg::MAG_W-1:0];
			end
			D_SQA: begin
				sq_q   <= grwd_pkg::SQ_W'(ua_q * ua_q);
				dist_q <= grwd_pkg::DIST_MAX;
			end
			D_SQB: begin
				sq2_q <= grwd_pkg::SQ_W'(prod_q[grwd_pkg::DIST_W-1:0]
					* prod_q[grwd_pkg::DIST_W-1:0]);
			end
			D_ADD: begin
				v_q <= sq_q + sq2_q;
				r_q <= '0;
				b_q <= grwd_pkg::SQ_W'(1) << (grwd_pkg::SQ_W - 2);
			end
			D_ROOT: begin
				v_q <= v_n;
				r_q <= r_n;
				b_q <= b_q >> 2;
				if (r_n > grwd_pkg::SQ_W'(grwd_pkg::DIST_MAX)) begin
					dist_q <= grwd_pkg::DIST_MAX;
				end else begin
					dist_q <= r_n[grwd_pkg::DIST_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						if (ua_full == '0 || req.fa == '0
							|| ua_full > grwd_pkg::LINE_W'(grwd_pkg::DIST_MAX)) begin
							state_q <= D_DONE;
						end else begin
							state_q <= D_MUL;
						end
					end
				end
				D_MUL: begin
					cnt_q   <= '0;
					state_q <= D_DIV;
				end
				D_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == grwd_pkg::CNT_W'(grwd_pkg::DIV_STEPS - 1)) begin
						state_q <= D_SQA;
					end
				end
				D_SQA: begin
					if (prod_q > grwd_pkg::QPROD_W'(grwd_pkg::DIST_MAX)) begin
						state_q <= D_DONE;
					end else begin
						state_q <= D_SQB;
					end
				end
				D_SQB: begin
					state_q <= D_ADD;
				end
				D_ADD: begin
					cnt_q   <= '0;
					state_q <= D_ROOT;
				end
				D_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == grwd_pkg::CNT_W'(grwd_pkg::ROOT_STEPS - 1)) begin
						state_q <= D_DONE;
					end
				end
				D_DONE: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/grwd_front.sv
// ----------------------------------------------------------------------------
// grwd_front
// Grid size registers and item classification: tile writes, zero-direction
// queries and walking queries with start cell and first crossing distances.
// ----------------------------------------------------------------------------
`default_nettype none

module grwd_front #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [grwd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [grwd_pkg::DIM_W-1:0]        cfg_wdata,
	input  wire logic                              kind,
	input  wire logic [grwd_pkg::TILE_W-1:0]       tile_col,
	input  wire logic [grwd_pkg::TILE_W-1:0]       tile_row,
	input  wire logic                              tile_solid,
	input  wire logic signed [grwd_pkg::POS_W-1:0] pos_x,
	input  wire logic signed [grwd_pkg::POS_W-1:0] pos_y,
	input  wire logic signed [grwd_pkg::DIR_W-1:0] dir_x,
	input  wire logic signed [grwd_pkg::DIR_W-1:0] dir_y,
	output grwd_pkg::cmd_t                         cmd,
	output logic [grwd_pkg::EDIM_W-1:0]            gw_eff,
	output logic [grwd_pkg::EDIM_W-1:0]            gh_eff
);

	localparam logic [grwd_pkg::FC_W-1:0] FX_ONE = grwd_pkg::FC_W'(1) << FRAC_BITS;

	logic [grwd_pkg::DIM_W-1:0] gw_q;
	logic [grwd_pkg::DIM_W-1:0] gh_q;
	logic [grwd_pkg::EDIM_W-1:0] gw_ext;
	logic [grwd_pkg::EDIM_W-1:0] gh_ext;
	logic [grwd_pkg::FC_W-1:0]   fr_x;
	logic [grwd_pkg::FC_W-1:0]   fr_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= grwd_pkg::DIM_W'(64);
			gh_q <= grwd_pkg::DIM_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				grwd_pkg::CFG_GRID_WIDTH:  gw_q <= cfg_wdata;
				grwd_pkg::CFG_GRID_HEIGHT: gh_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign gw_ext = grwd_pkg::EDIM_W'(gw_q);
	assign gh_ext = grwd_pkg::EDIM_W'(gh_q);

	assign gw_eff = (gw_q == '0) ? grwd_pkg::EDIM_W'(1)
		: (gw_ext > grwd_pkg::EDIM_W'(MAX_WIDTH)) ? grwd_pkg::EDIM_W'(MAX_WIDTH) : gw_ext;
	assign gh_eff = (gh_q == '0) ? grwd_pkg::EDIM_W'(1)
		: (gh_ext > grwd_pkg::EDIM_W'(MAX_HEIGHT)) ? grwd_pkg::EDIM_W'(MAX_HEIGHT) : gh_ext;

	assign fr_x = grwd_pkg::FC_W'(pos_x[FRAC_BITS-1:0]);
	assign fr_y = grwd_pkg::FC_W'(pos_y[FRAC_BITS-1:0]);

	always_comb begin
		if (!kind) begin
			cmd.op = grwd_pkg::OP_WRITE;
		end else if (dir_x == '0 && dir_y == '0) begin
			cmd.op = grwd_pkg::OP_ZERO;
		end else begin
			cmd.op = grwd_pkg::OP_QUERY;
		end
		cmd.wr_en      = (grwd_pkg::EDIM_W'(tile_col) < gw_eff)
			&& (grwd_pkg::EDIM_W'(tile_row) < gh_eff);
		cmd.tile_col   = tile_col;
		cmd.tile_row   = tile_row;
		cmd.tile_solid = tile_solid;
		cmd.pos_x      = pos_x;
		cmd.pos_y      = pos_y;
		cmd.dir_x      = dir_x;
		cmd.dir_y      = dir_y;
		cmd.cell_x     = grwd_pkg::CELL_W'(pos_x >>> FRAC_BITS);
		cmd.cell_y     = grwd_pkg::CELL_W'(pos_y >>> FRAC_BITS);
		cmd.fc_x       = !dir_x[grwd_pkg::DIR_W-1] ? (FX_ONE - fr_x)
			: ((fr_x != '0) ? fr_x : FX_ONE);
		cmd.fc_y       = !dir_y[grwd_pkg::DIR_W-1] ? (FX_ONE - fr_y)
			: ((fr_y != '0) ? fr_y : FX_ONE);
	end

endmodule

`default_nettype wire

// File: src/grwd_back.sv
// ----------------------------------------------------------------------------
// grwd_back
// Solid map, clearing pass, tile writes and the grid walk; hands the final
// offset to the distance unit and queues the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module grwd_back #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire grwd_pkg::cmd_t               cmd,
	input  wire logic                         cmd_empty,
	output logic                              cmd_pop,
	input  wire logic [grwd_pkg::EDIM_W-1:0]  gw_eff,
	input  wire logic [grwd_pkg::EDIM_W-1:0]  gh_eff,
	output logic                              clearing,
	output logic                              res_push,
	output grwd_pkg::res_t                    res,
	input  wire logic                         res_full
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam logic signed [grwd_pkg::LINE_W-1:0] HALF =
		grwd_pkg::LINE_W'(1) << (FRAC_BITS - 1);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_INIT  = 8'b0000_0100,
		ST_INIT2 = 8'b0000_1000,
		ST_READ  = 8'b0001_0000,
		ST_CHECK = 8'b0010_0000,
		ST_DIST  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t                               state_q;
	logic [AW-1:0]                        clr_q;
	logic signed [grwd_pkg::POS_W-1:0]    pos_x_q;
	logic signed [grwd_pkg::POS_W-1:0]    pos_y_q;
	logic signed [grwd_pkg::DIR_W-1:0]    dir_x_q;
	logic signed [grwd_pkg::DIR_W-1:0]    dir_y_q;
	logic signed [grwd_pkg::CELL_W-1:0]   cell_x_q;
	logic signed [grwd_pkg::CELL_W-1:0]   cell_y_q;
	logic [grwd_pkg::FC_W-1:0]            fc_x_q;
	logic [grwd_pkg::FC_W-1:0]            fc_y_q;
	logic [grwd_pkg::PROD_W-1:0]          tx_q;
	logic [grwd_pkg::PROD_W-1:0]          ty_q;
	logic                                 last_q;
	logic                                 stepped_q;
	logic                                 hit_q;
	logic [grwd_pkg::DIST_W-1:0]          dist_q;

	logic                                 ram_we;
	logic [AW-1:0]                        ram_waddr;
	logic                                 ram_wdata;
	logic [AW-1:0]                        ram_raddr;
	logic                                 ram_rdata;
	logic [AW-1:0]                        wr_addr;

	logic [grwd_pkg::MAG_W-1:0]           adx;
	logic [grwd_pkg::MAG_W-1:0]           ady;
	logic signed [grwd_pkg::CELL_W-1:0]   gw_s;
	logic signed [grwd_pkg::CELL_W-1:0]   gh_s;
	logic                                 dx_zero;
	logic                                 dy_zero;
	logic                                 dx_pos;
	logic                                 dy_pos;
	logic                                 inx;
	logic                                 iny;
	logic                                 solid;
	logic                                 xb;
	logic                                 yb;
	logic                                 fin_y;
	logic                                 fin_x;
	logic                                 take_x;
	logic signed [grwd_pkg::CELL_W-1:0]   cxl;
	logic signed [grwd_pkg::CELL_W-1:0]   cyl;
	logic signed [grwd_pkg::LINE_W-1:0]   line_x;
	logic signed [grwd_pkg::LINE_W-1:0]   line_y;
	logic                                 dist_start;
	grwd_pkg::dist_req_t                  dist_req;
	logic                                 dist_done;
	logic [grwd_pkg::DIST_W-1:0]          dist_val;

	assign clearing = (state_q == ST_CLEAR);
	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
	assign res_push = (state_q == ST_OUT) && !res_full;
	assign res.hit_solid = hit_q;
	assign res.distance  = dist_q;

	assign wr_addr   = AW'(int'(cmd.tile_row) * MAX_WIDTH + int'(cmd.tile_col));
	assign ram_we    = clearing
		|| (cmd_pop && cmd.op == grwd_pkg::OP_WRITE && cmd.wr_en);
	assign ram_waddr = clearing ? clr_q : wr_addr;
	assign ram_wdata = clearing ? 1'b0 : cmd.tile_solid;
	assign ram_raddr = AW'(int'(cell_y_q) * MAX_WIDTH + int'(cell_x_q));

	grwd_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign adx = dir_x_q[grwd_pkg::DIR_W-1] ?
		(grwd_pkg::MAG_W'(0) - {dir_x_q[grwd_pkg::DIR_W-1], dir_x_q}) : {1'b0, dir_x_q};
	assign ady = dir_y_q[grwd_pkg::DIR_W-1] ?
		(grwd_pkg::MAG_W'(0) - {dir_y_q[grwd_pkg::DIR_W-1], dir_y_q}) : {1'b0, dir_y_q};

	assign gw_s    = grwd_pkg::CELL_W'(gw_eff);
	assign gh_s    = grwd_pkg::CELL_W'(gh_eff);
	assign dx_zero = (dir_x_q == '0);
	assign dy_zero = (dir_y_q == '0);
	assign dx_pos  = !dx_zero && !dir_x_q[grwd_pkg::DIR_W-1];
	assign dy_pos  = !dy_zero && !dir_y_q[grwd_pkg::DIR_W-1];

	assign inx   = !cell_x_q[grwd_pkg::CELL_W-1] && (cell_x_q < gw_s);
	assign iny   = !cell_y_q[grwd_pkg::CELL_W-1] && (cell_y_q < gh_s);
	assign solid = inx && iny && ram_rdata;
	assign xb    = dx_pos ? (cell_x_q >= gw_s) : cell_x_q[grwd_pkg::CELL_W-1];
	assign yb    = dy_pos ? (cell_y_q >= gh_s) : cell_y_q[grwd_pkg::CELL_W-1];
	assign fin_y = (solid && last_q) || yb;
	assign fin_x = solid || xb;
	assign take_x = dx_zero ? 1'b0 : (dy_zero ? 1'b1 : (tx_q < ty_q));

	assign cxl = dx_pos ? cell_x_q : (cell_x_q + grwd_pkg::CELL_W'(1));
	assign cyl = dy_pos ? cell_y_q : (cell_y_q + grwd_pkg::CELL_W'(1));

	always_comb begin
		if (solid) begin
			if (!stepped_q) begin
				line_x = (grwd_pkg::LINE_W'(cell_x_q) <<< FRAC_BITS) + HALF;
			end else begin
				line_x = grwd_pkg::LINE_W'(cxl) <<< FRAC_BITS;
			end
			line_y = grwd_pkg::LINE_W'(cyl) <<< FRAC_BITS;
		end else begin
			line_x = dx_pos ? (grwd_pkg::LINE_W'(gw_eff) << FRAC_BITS) : '0;
			line_y = dy_pos ? (grwd_pkg::LINE_W'(gh_eff) << FRAC_BITS) : '0;
		end
		if (fin_y) begin
			dist_req.d  = grwd_pkg::LINE_W'(pos_y_q) - line_y;
			dist_req.fa = dir_y_q;
			dist_req.fo = dir_x_q;
		end else begin
			dist_req.d  = grwd_pkg::LINE_W'(pos_x_q) - line_x;
			dist_req.fa = dir_x_q;
			dist_req.fo = dir_y_q;
		end
	end

	assign dist_start = (state_q == ST_CHECK) && (fin_x || fin_y);

	grwd_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dist_start),
		.req      (dist_req),
		.done     (dist_done),
		.dist_len (dist_val)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pos_x_q  <= cmd.pos_x;
				pos_y_q  <= cmd.pos_y;
				dir_x_q  <= cmd.dir_x;
				dir_y_q  <= cmd.dir_y;
				cell_x_q <= cmd.cell_x;
				cell_y_q <= cmd.cell_y;
				fc_x_q   <= cmd.fc_x;
				fc_y_q   <= cmd.fc_y;
				hit_q    <= 1'b0;
				dist_q   <= '0;
			end
			ST_INIT: begin
				tx_q <= grwd_pkg::PROD_W'(fc_x_q * ady);
			end
			ST_INIT2: begin
				ty_q <= grwd_pkg::PROD_W'(fc_y_q * adx);
			end
			ST_CHECK: begin
				hit_q <= solid;
				if (!fin_x && !fin_y) begin
					if (take_x) begin
						cell_x_q <= dx_pos ? (cell_x_q + grwd_pkg::CELL_W'(1))
							: (cell_x_q - grwd_pkg::CELL_W'(1));
						tx_q     <= tx_q + (grwd_pkg::PROD_W'(ady) << FRAC_BITS);
					end else begin
						cell_y_q <= dy_pos ? (cell_y_q + grwd_pkg::CELL_W'(1))
							: (cell_y_q - grwd_pkg::CELL_W'(1));
						ty_q     <= ty_q + (grwd_pkg::PROD_W'(adx) << FRAC_BITS);
					end
				end
			end
			ST_DIST: begin
				dist_q <= dist_val;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			last_q    <= 1'b0;
			stepped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					last_q    <= 1'b0;
					stepped_q <= 1'b0;
					if (!cmd_empty) begin
						case (cmd.op)
							grwd_pkg::OP_QUERY: state_q <= ST_INIT;
							grwd_pkg::OP_ZERO:  state_q <= ST_OUT;
							default:            state_q <= ST_IDLE;
						endcase
					end
				end
				ST_INIT: begin
					state_q <= ST_INIT2;
				end
				ST_INIT2: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (fin_x || fin_y) begin
						state_q <= ST_DIST;
					end else begin
						last_q    <= !take_x;
						stepped_q <= 1'b1;
						state_q   <= ST_READ;
					end
				end
				ST_DIST: begin
					if (dist_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/grid_ray_wall_distance_core.sv
// ----------------------------------------------------------------------------
// grid_ray_wall_distance_core
// Solid tile map with grid ray walk queries that return the distance to the
// first wall or to the grid border.
//
//   channel   handshake          words
//   in        push / full        kind, tile_col, tile_row, tile_solid,
//                                pos_x, pos_y, dir_x, dir_y
//   out       empty / pop        distance, hit_solid
//   cfg       cfg_we             cfg_index, cfg_wdata (grid_width, grid_height)
//
// A tile write is done in the back end as it is popped; a zero-direction query goes
// straight to output. A walking query runs setup, walk and output (map read and step
// decision alternate), then waits on the distance unit (40-step divide, 25-step
// square root).
// After reset all MAX_WIDTH * MAX_HEIGHT map entries (4096 at the defaults) are
// cleared, with full held high; cfg writes are taken meanwhile.
// A two-word queue on each side lets input and result stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_wall_distance_core #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [grwd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [grwd_pkg::DIM_W-1:0]        cfg_wdata,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              kind,
	input  wire logic [grwd_pkg::TILE_W-1:0]       tile_col,
	input  wire logic [grwd_pkg::TILE_W-1:0]       tile_row,
	input  wire logic                              tile_solid,
	input  wire logic signed [grwd_pkg::POS_W-1:0] pos_x,
	input  wire logic signed [grwd_pkg::POS_W-1:0] pos_y,
	input  wire logic signed [grwd_pkg::DIR_W-1:0] dir_x,
	input  wire logic signed [grwd_pkg::DIR_W-1:0] dir_y,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [grwd_pkg::DIST_W-1:0]            distance,
	output logic                                   hit_solid
);

	grwd_pkg::cmd_t                   cmd_in;
	grwd_pkg::cmd_t                   cmd_out;
	logic [grwd_pkg::EDIM_W-1:0]      gw_eff;
	logic [grwd_pkg::EDIM_W-1:0]      gh_eff;
	logic                             cmd_full;
	logic                             cmd_empty;
	logic                             cmd_pop;
	logic                             cmd_push;
	logic                             clearing;
	logic                             res_push;
	logic                             res_full;
	grwd_pkg::res_t                   res_in;
	grwd_pkg::res_t                   res_out;

	assign full     = cmd_full || clearing;
	assign cmd_push = push && !full;

	grwd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.kind       (kind),
		.tile_col   (tile_col),
		.tile_row   (tile_row),
		.tile_solid (tile_solid),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.dir_x      (dir_x),
		.dir_y      (dir_y),
		.cmd        (cmd_in),
		.gw_eff     (gw_eff),
		.gh_eff     (gh_eff)
	);

	grwd_fifo #(
		.WIDTH ($bits(grwd_pkg::cmd_t)),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	grwd_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.gw_eff    (gw_eff),
		.gh_eff    (gh_eff),
		.clearing  (clearing),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	grwd_fifo #(
		.WIDTH ($bits(grwd_pkg::res_t)),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign distance  = res_out.distance;
	assign hit_solid = res_out.hit_solid;

`ifndef SYNTHESIS
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("input accepted during map clearing");

	a_clear_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !res_push && !cmd_pop)
		else $error("back end active during map clearing");

	a_res_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result word pushed into full queue");

	a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command word popped from empty queue");
`endif

endmodule

`default_nettype wire
